// ----- src/tpr_pkg.sv -----
// Shared types and constants for the tick pacer with rate meter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tpr_pkg;

    localparam int CAP_W  = 10;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 32;
    localparam int IDX_W  = 3;

    localparam logic [CAP_W-1:0]  MSEC_PER_SEC  = 10'd1000;
    localparam logic [CAP_W-1:0]  FAST_CAP      = 10'd120;
    localparam logic [CAP_W-1:0]  SLOW_CAP      = 10'd30;
    localparam logic [TIME_W-1:0] WINDOW_MS     = 32'd1000;
    localparam logic [3:0]        DIV_LAST      = 4'd9;

    typedef enum logic [1:0] {
        CMD_SCHEDULE = 2'd0,
        CMD_TICK     = 2'd1,
        CMD_FRAME    = 2'd2,
        CMD_RESUME   = 2'd3
    } t_cmd;

    typedef enum logic [IDX_W-1:0] {
        CFG_RATE_CAP    = 3'd0,
        CFG_HARD_PAUSE  = 3'd1,
        CFG_SOFT_PAUSE  = 3'd2,
        CFG_FAST        = 3'd3,
        CFG_SLOW        = 3'd4,
        CFG_SINGLE_STEP = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_DONE = 2'd2
    } t_state;

    typedef struct packed {
        logic latch;
        logic div_start;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_status;

endpackage

// ----- src/tpr_div.sv -----
// Restoring divider, one quotient bit per cycle, for the pacing interval.
// Depends on tpr_pkg.
`timescale 1ns / 1ps

module tpr_div
    import tpr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CAP_W-1:0] i_divisor,
    output logic             o_done,
    output logic [CAP_W-1:0] o_quotient
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [3:0]       r_cnt, n_cnt;
    logic [CAP_W-1:0] r_rem, n_rem;
    logic [CAP_W-1:0] r_quo, n_quo;
    logic [CAP_W-1:0] r_div, n_div;
    logic [CAP_W:0]   w_shift;
    logic [CAP_W:0]   w_diff;

    assign w_shift = {r_rem, r_quo[CAP_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = MSEC_PER_SEC;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_div}) begin
                n_rem = w_diff[CAP_W-1:0];
                n_quo = {r_quo[CAP_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[CAP_W-1:0];
                n_quo = {r_quo[CAP_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == DIV_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- src/tpr_datapath.sv -----
// Datapath: config registers, input hold, pacing decision, rate meters, result word.
// Depends on tpr_pkg and tpr_div.
`timescale 1ns / 1ps

module tpr_datapath
    import tpr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    output t_dp_status        o_status,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CAP_W-1:0]  i_cfg_data,
    input  logic [1:0]        i_command,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic              i_multi,
    input  logic              i_allow,
    input  logic              i_ready,
    output logic              o_grant,
    output logic              o_step_hold,
    output logic [CAP_W-1:0]  o_wait_left_ms,
    output logic [CNT_W-1:0]  o_tick_count,
    output logic [CNT_W-1:0]  o_tick_rate,
    output logic [CNT_W-1:0]  o_frame_count,
    output logic [CNT_W-1:0]  o_frame_rate
);

    // configuration
    logic [CAP_W-1:0] r_rate_cap;
    logic r_hard, r_soft, r_fast, r_slow, r_step_mode;

    // held input word
    t_cmd              r_in_cmd;
    logic [TIME_W-1:0] r_in_now;
    logic              r_in_multi, r_in_allow, r_in_ready;

    // block state
    logic [CNT_W-1:0]  r_tick_cnt, n_tick_cnt, r_tick_sc, n_tick_sc, r_tick_rate, n_tick_rate;
    logic [TIME_W-1:0] r_tick_st, n_tick_st;
    logic [CNT_W-1:0]  r_frm_cnt, n_frm_cnt, r_frm_sc, n_frm_sc, r_frm_rate, n_frm_rate;
    logic [TIME_W-1:0] r_frm_st, n_frm_st;
    logic [TIME_W-1:0] r_last, n_last;
    logic              r_resume, n_resume, r_armed, n_armed;

    // result word
    logic             r_run, n_run, r_blk, n_blk;
    logic [CAP_W-1:0] r_wait, n_wait;

    logic [CAP_W-1:0]  w_cap;
    logic [CAP_W-1:0]  w_interval;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_div_done;

    // meter on selected counter
    logic [CNT_W-1:0]  w_m_cnt, w_m_sc, w_m_rate, w_m_n;
    logic [TIME_W-1:0] w_m_st, w_m_diff;
    logic [CNT_W-1:0]  w_mo_sc, w_mo_rate;
    logic [TIME_W-1:0] w_mo_st;

    always_comb begin
        w_cap = r_rate_cap;
        if (r_fast) w_cap = FAST_CAP;
        if (r_slow) w_cap = SLOW_CAP;
    end

    tpr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_divisor  (w_cap),
        .o_done     (w_div_done),
        .o_quotient (w_interval)
    );

    assign o_status.div_done = w_div_done;
    assign w_elapsed = r_in_now - r_last;

    always_comb begin
        if (r_in_cmd == CMD_FRAME) begin
            w_m_cnt  = r_frm_cnt;
            w_m_sc   = r_frm_sc;
            w_m_st   = r_frm_st;
            w_m_rate = r_frm_rate;
        end else begin
            w_m_cnt  = r_tick_cnt;
            w_m_sc   = r_tick_sc;
            w_m_st   = r_tick_st;
            w_m_rate = r_tick_rate;
        end
        w_m_n     = w_m_cnt + 32'd1;
        w_m_diff  = r_in_now - w_m_st;
        w_mo_sc   = w_m_sc;
        w_mo_st   = w_m_st;
        w_mo_rate = w_m_rate;
        if (w_m_st == '0) begin
            w_mo_sc = w_m_n;
            w_mo_st = r_in_now;
        end else if (w_m_diff > WINDOW_MS) begin
            w_mo_st   = r_in_now;
            w_mo_rate = w_m_n - w_m_sc;
            w_mo_sc   = w_m_n;
        end
    end

    always_comb begin
        n_tick_cnt  = r_tick_cnt;
        n_tick_sc   = r_tick_sc;
        n_tick_st   = r_tick_st;
        n_tick_rate = r_tick_rate;
        n_frm_cnt   = r_frm_cnt;
        n_frm_sc    = r_frm_sc;
        n_frm_st    = r_frm_st;
        n_frm_rate  = r_frm_rate;
        n_last      = r_last;
        n_resume    = r_resume;
        n_armed     = r_armed;
        n_run       = 1'b0;
        n_blk       = 1'b0;
        n_wait      = '0;
        unique case (r_in_cmd)
            CMD_SCHEDULE: begin
                if (!r_hard) begin
                    if (r_in_multi) begin
                        if (r_in_allow) begin
                            n_last = r_in_now;
                            n_run  = 1'b1;
                        end
                    end else if (r_rate_cap != '0 &&
                                 w_elapsed < {{(TIME_W-CAP_W){1'b0}}, w_interval}) begin
                        n_wait = w_interval - w_elapsed[CAP_W-1:0];
                    end else if (!(r_soft && !r_resume)) begin
                        n_resume = 1'b0;
                        if (r_step_mode && r_armed && r_in_ready) begin
                            n_blk = 1'b1;
                        end else begin
                            if (r_step_mode) n_armed = 1'b1;
                            n_last = r_in_now;
                            n_run  = 1'b1;
                        end
                    end
                end
            end
            CMD_TICK: begin
                n_tick_cnt  = w_m_n;
                n_tick_sc   = w_mo_sc;
                n_tick_st   = w_mo_st;
                n_tick_rate = w_mo_rate;
            end
            CMD_FRAME: begin
                n_frm_cnt  = w_m_n;
                n_frm_sc   = w_mo_sc;
                n_frm_st   = w_mo_st;
                n_frm_rate = w_mo_rate;
            end
            CMD_RESUME: begin
                n_resume = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_cap  <= '0;
            r_hard      <= 1'b0;
            r_soft      <= 1'b0;
            r_fast      <= 1'b0;
            r_slow      <= 1'b0;
            r_step_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RATE_CAP:    r_rate_cap  <= i_cfg_data;
                CFG_HARD_PAUSE:  r_hard      <= i_cfg_data[0];
                CFG_SOFT_PAUSE:  r_soft      <= i_cfg_data[0];
                CFG_FAST:        r_fast      <= i_cfg_data[0];
                CFG_SLOW:        r_slow      <= i_cfg_data[0];
                CFG_SINGLE_STEP: r_step_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in_cmd   <= t_cmd'(i_command);
            r_in_now   <= i_now_ms;
            r_in_multi <= i_multi;
            r_in_allow <= i_allow;
            r_in_ready <= i_ready;
        end
        if (i_cmd.commit) begin
            r_run  <= n_run;
            r_blk  <= n_blk;
            r_wait <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_cnt  <= '0;
            r_tick_sc   <= '0;
            r_tick_st   <= '0;
            r_tick_rate <= '0;
            r_frm_cnt   <= '0;
            r_frm_sc    <= '0;
            r_frm_st    <= '0;
            r_frm_rate  <= '0;
            r_last      <= '0;
            r_resume    <= 1'b0;
            r_armed     <= 1'b0;
        end else if (i_cmd.commit) begin
            r_tick_cnt  <= n_tick_cnt;
            r_tick_sc   <= n_tick_sc;
            r_tick_st   <= n_tick_st;
            r_tick_rate <= n_tick_rate;
            r_frm_cnt   <= n_frm_cnt;
            r_frm_sc    <= n_frm_sc;
            r_frm_st    <= n_frm_st;
            r_frm_rate  <= n_frm_rate;
            r_last      <= n_last;
            r_resume    <= n_resume;
            r_armed     <= n_armed;
        end
    end

    assign o_grant        = r_run;
    assign o_step_hold    = r_blk;
    assign o_wait_left_ms = r_wait;
    assign o_tick_count   = r_tick_cnt;
    assign o_tick_rate    = r_tick_rate;
    assign o_frame_count  = r_frm_cnt;
    assign o_frame_rate   = r_frm_rate;

endmodule

// ----- src/tpr_ctrl.sv -----
// Controller: sequences accept, interval divide and commit, and owns output valid.
// Depends on tpr_pkg.
`timescale 1ns / 1ps

module tpr_ctrl
    import tpr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid)        n_state = ST_DIV;
            ST_DIV:  if (i_status.div_done) n_state = ST_DONE;
            ST_DONE: if (w_slot_free)       n_state = ST_IDLE;
            default:                        n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.latch     = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.commit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.latch     = i_in_valid;
                o_cmd.div_start = i_in_valid;
            end
            ST_DONE: o_cmd.commit = w_slot_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit)     n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- src/tick_pacer_with_rate_meter_core.sv -----
// Tick pacer with rate meter: one result word per input word, stream in and out.
// A new input word is taken only in idle, once the last one has been committed;
// each waits on the 10-step shift-subtract divider that forms the 1000/cap interval.
// The output register frees the input side while a result waits to be taken.
// Reset is synchronous, active low: all config, counters and pacing state clear.
// Depends on tpr_pkg, tpr_ctrl, tpr_datapath (and tpr_div below it).
`timescale 1ns / 1ps

module tick_pacer_with_rate_meter_core
    import tpr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] now_ms, [32] multiplayer_session, [33] peers_allow,
    // [34] next_commands_ready, [39:35] zero
    input  logic [39:0]      s_axis_tdata,
    // [1:0] command
    input  logic [1:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [0] grant, [1] step_hold, [11:2] wait_left_ms, [43:12] tick_count,
    // [75:44] tick_rate, [107:76] frame_count, [139:108] frame_rate, [143:140] zero
    output logic [143:0]     m_axis_tdata,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CAP_W-1:0] i_cfg_data
);

    t_ctrl_cmd        w_cmd;
    t_dp_status       w_status;
    logic             w_run, w_blk;
    logic [CAP_W-1:0] w_wait;
    logic [CNT_W-1:0] w_tick_cnt, w_tick_rate, w_frm_cnt, w_frm_rate;

    assign o_cfg_ready = 1'b1;

    tpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tpr_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (s_axis_tuser),
        .i_now_ms       (s_axis_tdata[31:0]),
        .i_multi        (s_axis_tdata[32]),
        .i_allow        (s_axis_tdata[33]),
        .i_ready        (s_axis_tdata[34]),
        .o_grant        (w_run),
        .o_step_hold    (w_blk),
        .o_wait_left_ms (w_wait),
        .o_tick_count   (w_tick_cnt),
        .o_tick_rate    (w_tick_rate),
        .o_frame_count  (w_frm_cnt),
        .o_frame_rate   (w_frm_rate)
    );

    assign m_axis_tdata = {4'b0000, w_frm_rate, w_frm_cnt, w_tick_rate, w_tick_cnt,
                           w_wait, w_blk, w_run};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    a_run_blk_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("tick granted and blocked in the same word");

    a_wait_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[11:2] != '0) |-> !m_axis_tdata[0] && !m_axis_tdata[1])
        else $error("nonzero wait alongside grant or block");
`endif

endmodule
